// ===== hdl/gjinv_pkg.sv =====
package gjinv_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ORDER_W       = 4;
    localparam int IDX_W         = 3;
    localparam int M_TDATA_W     = 40;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT,
        S_PIV_RD,
        S_PIV_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SW_RDA,
        S_SW_RDB,
        S_SW_WRA,
        S_SW_WRB,
        S_NRM_RD,
        S_NRM_DIV,
        S_NRM_WAIT,
        S_ELIM_NEXT,
        S_ELIM_TCHK,
        S_ELIM_RA,
        S_ELIM_RB,
        S_ELIM_MUL,
        S_ELIM_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_SING
    } state_t;

    typedef enum logic [2:0] {
        WS_IN,
        WS_RD,
        WS_A,
        WS_QUO,
        WS_DIFF,
        WS_ONE,
        WS_ZERO
    } wsel_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_P,
        LD_T,
        LD_A
    } ld_t;

    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        wsel_t wsel;
        ld_t   ld;
        logic  div_start;
        logic  out_load;
        logic  out_sing;
        logic  out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_zero;
        logic div_done;
        logic out_free;
    } dp_sts_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7fffffff;
        end
        if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== hdl/gjinv_ram.sv =====
module gjinv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/gjinv_div.sv =====
module gjinv_div
    import gjinv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W-1:0] den,
    output logic                     done,
    output logic signed [DATA_W-1:0] quo
);

    localparam int QW = DATA_W + FRAC_BITS;
    localparam int CNW = $clog2(QW + 1);

    logic [DATA_W:0]   rem_reg, rem_next;
    logic [QW-1:0]     dvd_reg, dvd_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [CNW-1:0]    cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W-1:0] num_mag, den_mag;
    logic              big_pos, big_neg;

    assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    assign rem_sh  = {rem_reg[DATA_W-1:0], dvd_reg[QW-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = {num_mag, {FRAC_BITS{1'b0}}};
            den_next  = den_mag;
            cnt_next  = CNW'(QW);
            busy_next = 1'b1;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                dvd_next = {dvd_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign big_pos = |dvd_reg[QW-1:DATA_W-1];
    assign big_neg = (|dvd_reg[QW-1:DATA_W]) ||
                     (dvd_reg[DATA_W-1] && (|dvd_reg[DATA_W-2:0]));

    always_comb
    begin
        if (neg_reg)
        begin
            quo = big_neg ? 32'sh80000000 : DATA_W'(-dvd_reg[DATA_W-1:0]);
        end
        else
        begin
            quo = big_pos ? 32'sh7fffffff : dvd_reg[DATA_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== hdl/gjinv_dp.sv =====
module gjinv_dp
    import gjinv_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  dp_cmd_t                                       cmd,
    input  logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] row,
    input  logic [$clog2(2 * MAX_ORDER)-1:0]              col,
    input  logic [DATA_W-1:0]                             in_data,
    output dp_sts_t                                       sts,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [M_TDATA_W-1:0]                          m_tdata,
    output logic                                          m_tuser,
    output logic                                          m_tlast
);

    localparam int STRIDE = 2 * MAX_ORDER;
    localparam int DEPTH  = 2 * MAX_ORDER * MAX_ORDER;
    localparam int AW     = $clog2(DEPTH);
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'sd1 <<< FRAC_BITS);

    logic [AW-1:0]            addr;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] p_reg, t_reg, a_reg;
    logic signed [63:0]       prod_reg;
    logic signed [65:0]       diff;
    logic signed [DATA_W-1:0] quo;
    logic                     div_done;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_data_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic                     out_sing_reg, out_last_reg;

    assign addr = AW'(row) * AW'(STRIDE) + AW'(col);

    gjinv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (addr),
        .rdata (rd_data)
    );

    gjinv_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (rd_data),
        .den   (p_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign diff = 66'(rd_data) - 66'(prod_reg >>> FRAC_BITS);

    always_comb
    begin
        case (cmd.wsel)
            WS_IN:   wr_data = in_data;
            WS_RD:   wr_data = rd_data;
            WS_A:    wr_data = a_reg;
            WS_QUO:  wr_data = quo;
            WS_DIFF: wr_data = sat32(diff);
            WS_ONE:  wr_data = ONE;
            WS_ZERO: wr_data = '0;
            default: wr_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.ld)
            LD_P:    p_reg <= rd_data;
            LD_T:    t_reg <= rd_data;
            LD_A:    a_reg <= rd_data;
            default: ;
        endcase
        prod_reg <= a_reg * t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= cmd.out_sing ? '0 : rd_data;
            out_row_reg  <= cmd.out_sing ? '0 : IDX_W'(row);
            out_col_reg  <= cmd.out_sing ? '0 : IDX_W'(col);
            out_sing_reg <= cmd.out_sing;
            out_last_reg <= cmd.out_last;
        end
    end

    assign sts.rd_zero  = (rd_data == '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_row_reg, out_data_reg};
    assign m_tuser  = out_sing_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/gjinv_ctrl.sv =====
module gjinv_ctrl
    import gjinv_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_wr_en,
    input  logic [ORDER_W-1:0]                            cfg_wr_data,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  dp_sts_t                                       sts,
    output dp_cmd_t                                       cmd,
    output logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] row,
    output logic [$clog2(2 * MAX_ORDER)-1:0]              col
);

    localparam int RW = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;
    localparam int CW = $clog2(2 * MAX_ORDER);
    localparam int NW = $clog2(MAX_ORDER + 1);
    localparam int KW = $clog2(2 * MAX_ORDER + 1);

    state_t             state_reg, state_next;
    logic [NW-1:0]      i_reg, i_next;
    logic [NW-1:0]      j_reg, j_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [ORDER_W-1:0] order_reg, order_next;
    logic [NW-1:0]      n, n_m1;
    logic [KW-1:0]      k_last, n_k;
    logic [NW-1:0]      arow;
    logic [KW-1:0]      acol;

    always_comb
    begin
        if (order_reg == '0)
        begin
            n = NW'(1);
        end
        else if (32'(order_reg) > MAX_ORDER)
        begin
            n = NW'(MAX_ORDER);
        end
        else
        begin
            n = NW'(order_reg);
        end
    end

    assign n_m1   = n - NW'(1);
    assign n_k    = KW'(n);
    assign k_last = n_k + n_k - KW'(1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        order_next = order_reg;
        cmd        = '0;
        arow       = i_reg;
        acol       = k_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wsel  = WS_IN;
                    if (k_reg == KW'(n_m1))
                    begin
                        k_next = '0;
                        if (i_reg == n_m1)
                        begin
                            i_next     = '0;
                            state_next = S_INIT;
                        end
                        else
                        begin
                            i_next = i_reg + NW'(1);
                        end
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
                if (cfg_wr_en)
                begin
                    order_next = cfg_wr_data;
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_LOAD;
                end
            end
            S_INIT:
            begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = (KW'(i_reg) == k_reg) ? WS_ONE : WS_ZERO;
                acol      = n_k + k_reg;
                if (k_reg == KW'(n_m1))
                begin
                    k_next = '0;
                    if (i_reg == n_m1)
                    begin
                        i_next     = '0;
                        state_next = S_PIV_RD;
                    end
                    else
                    begin
                        i_next = i_reg + NW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_PIV_RD:
            begin
                cmd.rd_en  = 1'b1;
                acol       = KW'(i_reg);
                state_next = S_PIV_CHK;
            end
            S_PIV_CHK:
            begin
                if (!sts.rd_zero)
                begin
                    cmd.ld     = LD_P;
                    k_next     = KW'(i_reg);
                    state_next = S_NRM_RD;
                end
                else if (i_reg == n_m1)
                begin
                    state_next = S_SING;
                end
                else
                begin
                    j_next     = i_reg + NW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                arow       = j_reg;
                acol       = KW'(i_reg);
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (!sts.rd_zero)
                begin
                    k_next     = KW'(i_reg);
                    state_next = S_SW_RDA;
                end
                else if (j_reg == n_m1)
                begin
                    state_next = S_SING;
                end
                else
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_SW_RDA:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SW_RDB;
            end
            S_SW_RDB:
            begin
                cmd.ld     = LD_A;
                cmd.rd_en  = 1'b1;
                arow       = j_reg;
                state_next = S_SW_WRA;
            end
            S_SW_WRA:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wsel   = WS_RD;
                state_next = S_SW_WRB;
            end
            S_SW_WRB:
            begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = WS_A;
                arow      = j_reg;
                if (k_reg == k_last)
                begin
                    state_next = S_PIV_RD;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_SW_RDA;
                end
            end
            S_NRM_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_NRM_DIV;
            end
            S_NRM_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_NRM_WAIT;
            end
            S_NRM_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wsel  = WS_QUO;
                    if (k_reg == k_last)
                    begin
                        j_next     = '0;
                        state_next = S_ELIM_NEXT;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_NRM_RD;
                    end
                end
            end
            S_ELIM_NEXT:
            begin
                arow = j_reg;
                acol = KW'(i_reg);
                if (j_reg == n)
                begin
                    if (i_reg == n_m1)
                    begin
                        j_next     = '0;
                        k_next     = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + NW'(1);
                        state_next = S_PIV_RD;
                    end
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + NW'(1);
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_ELIM_TCHK;
                end
            end
            S_ELIM_TCHK:
            begin
                if (sts.rd_zero)
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = S_ELIM_NEXT;
                end
                else
                begin
                    cmd.ld     = LD_T;
                    k_next     = KW'(i_reg);
                    state_next = S_ELIM_RA;
                end
            end
            S_ELIM_RA:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ELIM_RB;
            end
            S_ELIM_RB:
            begin
                cmd.ld     = LD_A;
                cmd.rd_en  = 1'b1;
                arow       = j_reg;
                state_next = S_ELIM_MUL;
            end
            S_ELIM_MUL:
            begin
                state_next = S_ELIM_WR;
            end
            S_ELIM_WR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wsel  = WS_DIFF;
                arow      = j_reg;
                if (k_reg == k_last)
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = S_ELIM_NEXT;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_ELIM_RA;
                end
            end
            S_OUT_RD:
            begin
                cmd.rd_en  = 1'b1;
                arow       = j_reg;
                acol       = n_k + k_reg;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                arow = j_reg;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (j_reg == n_m1) && (k_reg == KW'(n_m1));
                    if (cmd.out_last)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        state_next = S_LOAD;
                    end
                    else if (k_reg == KW'(n_m1))
                    begin
                        k_next     = '0;
                        j_next     = j_reg + NW'(1);
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_SING:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sing = 1'b1;
                    cmd.out_last = 1'b1;
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                i_next     = '0;
                j_next     = '0;
                k_next     = '0;
                state_next = S_LOAD;
            end
        endcase
    end

    assign row = arow[RW-1:0];
    assign col = acol[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            order_reg <= ORDER_RESET;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            order_reg <= order_next;
        end
    end

endmodule

// ===== hdl/matrix_inverse_gauss_jordan.sv =====
// Matrix inverter by row reduction, one shared datapath around a single matrix RAM.
// Load: n*n input beats, one per cycle. Run time is set by the bit-serial divider
// and the one RAM port.
// Output: n*n beats, each read from the RAM and then loaded, held while m_tready is low; or one singular beat.
// Reset (rst_n, async low) clears control, load position and order (8); RAM is not cleared.
module matrix_inverse_gauss_jordan
    import gjinv_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [ORDER_W-1:0]   cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // element_value[31:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // inverse_value[31:0], out_row[34:32], out_col[37:35]
    output logic                 m_tuser,   // singular
    output logic                 m_tlast
);

    localparam int RW = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;
    localparam int CW = $clog2(2 * MAX_ORDER);

    dp_cmd_t       cmd;
    dp_sts_t       sts;
    logic [RW-1:0] row;
    logic [CW-1:0] col;

    gjinv_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .sts         (sts),
        .cmd         (cmd),
        .row         (row),
        .col         (col)
    );

    gjinv_dp #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .row      (row),
        .col      (col),
        .in_data  (s_tdata),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/gjinv_chk.sv =====
module gjinv_chk
    import gjinv_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("singular beat not a zero last beat");

    a_sing_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser |-> !$past(m_tvalid && m_tready && !m_tlast))
        else $error("singular beat follows inverse beats of the same run");

endmodule

bind matrix_inverse_gauss_jordan gjinv_chk u_chk (.*);
